// File: src/tmcw_pkg.sv
// Package for the text-mode character writer: operation codes, character codes,
// command classification types and default screen geometry.
// No dependencies; every other file of the block refers to it by scoped names.
package tmcw_pkg;

  // Default screen geometry and queue depth.
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int QUEUE_DEPTH    = 2;

  // Input operation codes.
  localparam logic [1:0] OP_WRITE_CURSOR = 2'd0;
  localparam logic [1:0] OP_WRITE_AT     = 2'd1;
  localparam logic [1:0] OP_READ_CELL    = 2'd2;

  // Character codes and the attribute value after reset.
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  // What the back end has to do with one item.
  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_NEWLINE = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NOP     = 2'd3
  } tmcw_kind_t;

  // Control part of a classified command.
  typedef struct packed {
    tmcw_kind_t  kind;
    logic        at_addr;    // use the given column and row, not the cursor
    logic [7:0]  character;
  } tmcw_cmd_ctl_t;

endpackage

// File: src/tmcw_front.sv
// Front end of the text-mode character writer: classifies an input item and
// turns its column and row into a saturated cell address.
// Depends on tmcw_pkg.
module tmcw_front #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS
) (
  input  logic [1:0]                  in_op,
  input  logic [7:0]                  in_character,
  input  logic [6:0]                  in_column,
  input  logic [4:0]                  in_line,
  output tmcw_pkg::tmcw_cmd_ctl_t     cmd_ctl,
  output logic [$clog2(SCREEN_COLUMNS)-1:0]             cmd_col,
  output logic [$clog2(SCREEN_ROWS)-1:0]                cmd_row,
  output logic [$clog2(SCREEN_COLUMNS*SCREEN_ROWS)-1:0] cmd_idx
);

  localparam int COL_W = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int IDX_W = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);

  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;

  // Out-of-range coordinates clamp to the last column or row.
  assign col_sat = (32'(in_column) >= SCREEN_COLUMNS) ? COL_W'(SCREEN_COLUMNS - 1)
                                                      : COL_W'(in_column);
  assign row_sat = (32'(in_line) >= SCREEN_ROWS) ? ROW_W'(SCREEN_ROWS - 1)
                                                 : ROW_W'(in_line);

  assign cmd_col = col_sat;
  assign cmd_row = row_sat;
  assign cmd_idx = IDX_W'(IDX_W'(row_sat) * IDX_W'(SCREEN_COLUMNS) + IDX_W'(col_sat));

  always_comb begin
    cmd_ctl.character = in_character;
    cmd_ctl.at_addr   = (in_op != tmcw_pkg::OP_WRITE_CURSOR);
    case (in_op)
      tmcw_pkg::OP_WRITE_CURSOR, tmcw_pkg::OP_WRITE_AT: begin
        cmd_ctl.kind = (in_character == tmcw_pkg::NEWLINE_CODE) ? tmcw_pkg::KIND_NEWLINE
                                                                 : tmcw_pkg::KIND_CHAR;
      end
      tmcw_pkg::OP_READ_CELL: begin
        cmd_ctl.kind = tmcw_pkg::KIND_READ;
      end
      default: begin
        cmd_ctl.kind = tmcw_pkg::KIND_NOP;
      end
    endcase
  end

endmodule

// File: src/tmcw_queue.sv
// Short command queue between the front and back ends of the text-mode
// character writer. Depends on tmcw_pkg for its default depth.
module tmcw_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = tmcw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] q_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push;
  logic             do_pop;

  // Nothing is taken while reset is held.
  assign push_ready = rst_n && (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/tmcw_back.sv
// Back end of the text-mode character writer: cell memory, cursor, attribute
// register, clearing and scrolling sweeps, and the result register.
// Depends on tmcw_pkg.
module tmcw_back #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cmd_valid,
  output logic                                          cmd_pop,
  input  tmcw_pkg::tmcw_cmd_ctl_t                       cmd_ctl,
  input  logic [$clog2(SCREEN_COLUMNS)-1:0]             cmd_col,
  input  logic [$clog2(SCREEN_ROWS)-1:0]                cmd_row,
  input  logic [$clog2(SCREEN_COLUMNS*SCREEN_ROWS)-1:0] cmd_idx,
  input  logic                                          cfg_write,
  input  logic [7:0]                                    cfg_data,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [10:0]                                   out_cursor_cell,
  output logic [7:0]                                    out_read_character,
  output logic [7:0]                                    out_read_attribute,
  output logic                                          out_scrolled
);

  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int COL_W          = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W          = $clog2(SCREEN_ROWS);
  localparam int IDX_W          = $clog2(CELL_COUNT);
  localparam int LAST_ROW_START = CELL_COUNT - SCREEN_COLUMNS;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FLUSH  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] sc_r, sc_nxt;
  logic             wb_valid_r, wb_valid_nxt;
  logic [IDX_W-1:0] wb_idx_r, wb_idx_nxt;
  logic             wb_last_r, wb_last_nxt;
  logic [7:0]       attr_r;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;
  logic [IDX_W-1:0] cur_idx_r, cur_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [10:0]      out_cursor_r, out_cursor_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic [7:0]       out_attr_r, out_attr_nxt;
  logic             out_scrolled_r, out_scrolled_nxt;

  logic [15:0]      mem [CELL_COUNT];
  logic [15:0]      rd_data_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [15:0]      mem_wdata;
  logic [IDX_W-1:0] mem_raddr;

  // Position that a write or newline works on, and where the cursor goes after it.
  logic [COL_W-1:0] pos_col;
  logic [ROW_W-1:0] pos_row;
  logic [IDX_W-1:0] pos_idx;
  logic             is_nl;
  logic             col_last;
  logic             row_last;
  logic             row_inc;
  logic             adv_scroll;
  logic [COL_W-1:0] adv_col;
  logic [ROW_W-1:0] adv_row;
  logic [IDX_W:0]   idx_raw;
  logic [IDX_W-1:0] adv_idx;
  logic             slot_free;

  assign pos_col    = cmd_ctl.at_addr ? cmd_col : cur_col_r;
  assign pos_row    = cmd_ctl.at_addr ? cmd_row : cur_row_r;
  assign pos_idx    = cmd_ctl.at_addr ? cmd_idx : cur_idx_r;
  assign is_nl      = (cmd_ctl.kind == tmcw_pkg::KIND_NEWLINE);
  assign col_last   = (pos_col == COL_W'(SCREEN_COLUMNS - 1));
  assign row_last   = (pos_row == ROW_W'(SCREEN_ROWS - 1));
  assign row_inc    = is_nl || col_last;
  assign adv_scroll = row_inc && row_last;
  assign adv_col    = row_inc ? '0 : pos_col + COL_W'(1);
  assign adv_row    = (row_inc && !row_last) ? pos_row + ROW_W'(1) : pos_row;
  // A newline lands on the first cell of the next row.
  assign idx_raw    = is_nl ? ((IDX_W+1)'(pos_idx) - (IDX_W+1)'(pos_col)
                               + (IDX_W+1)'(SCREEN_COLUMNS))
                            : ((IDX_W+1)'(pos_idx) + (IDX_W+1)'(1));
  assign adv_idx    = adv_scroll ? IDX_W'(idx_raw - (IDX_W+1)'(SCREEN_COLUMNS))
                                 : IDX_W'(idx_raw);

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid && slot_free;

  always_comb begin
    state_nxt        = state_r;
    sc_nxt           = sc_r;
    wb_valid_nxt     = 1'b0;
    wb_idx_nxt       = sc_r;
    wb_last_nxt      = (32'(sc_r) >= LAST_ROW_START);
    cur_col_nxt      = cur_col_r;
    cur_row_nxt      = cur_row_r;
    cur_idx_nxt      = cur_idx_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_cursor_nxt   = out_cursor_r;
    out_char_nxt     = out_char_r;
    out_attr_nxt     = out_attr_r;
    out_scrolled_nxt = out_scrolled_r;
    mem_we           = 1'b0;
    mem_waddr        = wb_idx_r;
    mem_wdata        = wb_last_r ? {rd_data_r[15:8], tmcw_pkg::SPACE_CODE} : rd_data_r;
    mem_raddr        = cmd_idx;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sc_r;
        mem_wdata = '0;
        if (sc_r == IDX_W'(CELL_COUNT - 1)) begin
          sc_nxt    = '0;
          state_nxt = ST_IDLE;
        end else begin
          sc_nxt = sc_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        if (cmd_pop) begin
          out_char_nxt = '0;
          out_attr_nxt = '0;
          case (cmd_ctl.kind)
            tmcw_pkg::KIND_CHAR, tmcw_pkg::KIND_NEWLINE: begin
              if (!is_nl) begin
                mem_we    = 1'b1;
                mem_waddr = pos_idx;
                mem_wdata = {attr_r, cmd_ctl.character};
              end
              cur_col_nxt      = adv_col;
              cur_row_nxt      = adv_row;
              cur_idx_nxt      = adv_idx;
              out_valid_nxt    = 1'b1;
              out_cursor_nxt   = 11'(adv_idx);
              out_scrolled_nxt = adv_scroll;
              if (adv_scroll) begin
                sc_nxt    = '0;
                state_nxt = ST_SCROLL;
              end
            end
            tmcw_pkg::KIND_READ: begin
              mem_raddr = cmd_idx;
              state_nxt = ST_READ;
            end
            default: begin
              out_valid_nxt    = 1'b1;
              out_cursor_nxt   = 11'(cur_idx_r);
              out_scrolled_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        out_valid_nxt    = 1'b1;
        out_cursor_nxt   = 11'(cur_idx_r);
        out_char_nxt     = rd_data_r[7:0];
        out_attr_nxt     = rd_data_r[15:8];
        out_scrolled_nxt = 1'b0;
        state_nxt        = ST_IDLE;
      end
      ST_SCROLL: begin
        // Read one cell a cycle; write it one row up on the following cycle.
        mem_raddr    = (32'(sc_r) < LAST_ROW_START) ? sc_r + IDX_W'(SCREEN_COLUMNS) : sc_r;
        mem_we       = wb_valid_r;
        wb_valid_nxt = 1'b1;
        if (sc_r == IDX_W'(CELL_COUNT - 1)) begin
          state_nxt = ST_FLUSH;
        end else begin
          sc_nxt = sc_r + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        mem_we    = wb_valid_r;
        sc_nxt    = '0;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sc_r        <= '0;
      wb_valid_r  <= 1'b0;
      attr_r      <= tmcw_pkg::ATTR_RESET;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      cur_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sc_r        <= sc_nxt;
      wb_valid_r  <= wb_valid_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_idx_r   <= cur_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        attr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    wb_idx_r       <= wb_idx_nxt;
    wb_last_r      <= wb_last_nxt;
    out_cursor_r   <= out_cursor_nxt;
    out_char_r     <= out_char_nxt;
    out_attr_r     <= out_attr_nxt;
    out_scrolled_r <= out_scrolled_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign out_valid          = out_valid_r;
  assign out_cursor_cell    = out_cursor_r;
  assign out_read_character = out_char_r;
  assign out_read_attribute = out_attr_r;
  assign out_scrolled       = out_scrolled_r;

endmodule

// File: src/text_mode_character_writer.sv
// Top level of the text-mode character writer: front end, command queue and
// back end. Depends on tmcw_pkg, tmcw_front, tmcw_queue and tmcw_back.
//
//   Port group   Direction  Handshake               Contents
//   in_*         input      in_valid / in_ready     op, character, column, line
//   out_*        output     out_valid / out_ready   cursor_cell, read_character,
//                                                   read_attribute, scrolled
//   cfg_*        input      cfg_valid / cfg_ready   text attribute byte
//
// A character write or newline is done in the back end's idle state, and a cell read
// passes through a read state as well, since the cell memory has a registered read port.
// An item that scrolls adds a sweep that moves one cell per cycle through the memory's
// one read port and one write port, and then a flush state. After reset the back end
// clears the memory while the queue takes up to QUEUE_DEPTH items; no channel is ready
// while reset is held. The back end takes an item only when the result register is empty
// or being read out, so a waiting result stalls it and the queue fills behind it.
module text_mode_character_writer #(
  parameter int SCREEN_COLUMNS = tmcw_pkg::SCREEN_COLUMNS,
  parameter int SCREEN_ROWS    = tmcw_pkg::SCREEN_ROWS,
  parameter int QUEUE_DEPTH    = tmcw_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_character,
  input  logic [6:0]  in_column,
  input  logic [4:0]  in_line,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [10:0] out_cursor_cell,
  output logic [7:0]  out_read_character,
  output logic [7:0]  out_read_attribute,
  output logic        out_scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int COL_W   = $clog2(SCREEN_COLUMNS);
  localparam int ROW_W   = $clog2(SCREEN_ROWS);
  localparam int IDX_W   = $clog2(SCREEN_COLUMNS * SCREEN_ROWS);
  localparam int CTL_W   = $bits(tmcw_pkg::tmcw_cmd_ctl_t);
  localparam int Q_WIDTH = CTL_W + COL_W + ROW_W + IDX_W;

  // Classified command from the front end.
  tmcw_pkg::tmcw_cmd_ctl_t f_ctl;
  logic [COL_W-1:0]        f_col;
  logic [ROW_W-1:0]        f_row;
  logic [IDX_W-1:0]        f_idx;

  // Command at the head of the queue.
  tmcw_pkg::tmcw_cmd_ctl_t b_ctl;
  logic [COL_W-1:0]        b_col;
  logic [ROW_W-1:0]        b_row;
  logic [IDX_W-1:0]        b_idx;

  logic [Q_WIDTH-1:0]      q_push_data;
  logic [Q_WIDTH-1:0]      q_pop_data;
  logic                    q_pop_valid;
  logic                    q_pop;

  tmcw_front #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_front (
    .in_op        (in_op),
    .in_character (in_character),
    .in_column    (in_column),
    .in_line      (in_line),
    .cmd_ctl      (f_ctl),
    .cmd_col      (f_col),
    .cmd_row      (f_row),
    .cmd_idx      (f_idx)
  );

  assign q_push_data = {f_ctl, f_col, f_row, f_idx};

  tmcw_queue #(
    .WIDTH (Q_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (q_push_data),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_data   (q_pop_data)
  );

  assign b_ctl = tmcw_pkg::tmcw_cmd_ctl_t'(q_pop_data[Q_WIDTH-1 -: CTL_W]);
  assign b_col = q_pop_data[IDX_W+ROW_W +: COL_W];
  assign b_row = q_pop_data[IDX_W +: ROW_W];
  assign b_idx = q_pop_data[IDX_W-1:0];

  // The attribute register takes a write in any cycle out of reset.
  assign cfg_ready = rst_n;

  tmcw_back #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_valid          (q_pop_valid),
    .cmd_pop            (q_pop),
    .cmd_ctl            (b_ctl),
    .cmd_col            (b_col),
    .cmd_row            (b_row),
    .cmd_idx            (b_idx),
    .cfg_write          (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_cell    (out_cursor_cell),
    .out_read_character (out_read_character),
    .out_read_attribute (out_read_attribute),
    .out_scrolled       (out_scrolled)
  );

endmodule

// File: test/testbench.sv
// Self-checking testbench for the text-mode character writer (80x25 cell console).
// A directed table and a long random run are checked against a predictor of the console.
// Depends on tmcw_pkg and the text_mode_character_writer top level only.
module testbench;

  localparam int COLS       = tmcw_pkg::SCREEN_COLUMNS;
  localparam int ROWS       = tmcw_pkg::SCREEN_ROWS;
  localparam int CELL_COUNT = COLS * ROWS;

  // The package names only the three defined operations; the fourth does nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 219;
  localparam int DRAIN_CYCLES    = 8;

  // Worst case is every item scrolling, each with a full sweep, behind long stalls,
  // plus the clearing pass after reset. The limit is several times that.
  localparam longint CYCLE_LIMIT = 20_000_000;

  // One item on the input channel and one result on the output channel.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] character;
    logic [6:0] column;
    logic [4:0] line;
  } console_item_t;

  typedef struct packed {
    logic [10:0] cursor_cell;
    logic [7:0]  read_character;
    logic [7:0]  read_attribute;
    logic        scrolled;
  } console_result_t;

  // A row of the directed table. Rows with has_result set carry a result worked
  // out by hand; the others are checked against the predictor.
  typedef struct packed {
    console_item_t   item;
    logic            has_result;
    console_result_t result;
  } directed_row_t;

  // The directed part starts right after reset with the attribute at its reset value.
  // It covers reads of a cleared store, writes of the extreme characters, saturation
  // of out-of-range columns and rows, a scroll by a write into the last cell, the
  // last row turning into spaces that keep their attribute, a newline at the cursor
  // on the last row, which scrolls, and one at a given cell higher up, and the unused op.
  localparam directed_row_t DIRECTED_ROWS [22] = '{
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd0,   5'd0},  1'b1,
      '{11'd0,    8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_CURSOR, 8'd255, 7'd0,   5'd0},  1'b1,
      '{11'd1,    8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_CURSOR, 8'd0,   7'd0,   5'd0},  1'b1,
      '{11'd2,    8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd0,   5'd0},  1'b1,
      '{11'd2,    8'd255, 8'd7, 1'b0}},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd127, 5'd31}, 1'b1,
      '{11'd2,    8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_AT,     8'd65,  7'd127, 5'd31}, 1'b1,
      '{11'd1920, 8'd0,   8'd0, 1'b1}},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd79,  5'd24}, 1'b1,
      '{11'd1920, 8'd32,  8'd7, 1'b0}},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd79,  5'd23}, 1'b1,
      '{11'd1920, 8'd65,  8'd7, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_CURSOR, tmcw_pkg::NEWLINE_CODE, 7'd0, 5'd0}, 1'b1,
      '{11'd1920, 8'd0,   8'd0, 1'b1}},
    '{'{tmcw_pkg::OP_WRITE_AT,     tmcw_pkg::NEWLINE_CODE, 7'd5, 5'd3}, 1'b1,
      '{11'd320,  8'd0,   8'd0, 1'b0}},
    '{'{OP_UNUSED,                 8'h55,  7'd3,   5'd7},  1'b1,
      '{11'd320,  8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_AT,     8'd0,   7'd0,   5'd0},  1'b1,
      '{11'd1,    8'd0,   8'd0, 1'b0}},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd0,   5'd0},  1'b1,
      '{11'd1,    8'd0,   8'd7, 1'b0}},
    '{'{tmcw_pkg::OP_WRITE_AT,     8'd170, 7'd85,  5'd21}, 1'b0, '0},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd79,  5'd21}, 1'b0, '0},
    '{'{tmcw_pkg::OP_WRITE_AT,     8'h2A,  7'd42,  5'd10}, 1'b0, '0},
    '{'{tmcw_pkg::OP_WRITE_CURSOR, tmcw_pkg::NEWLINE_CODE, 7'd0, 5'd0}, 1'b0, '0},
    '{'{OP_UNUSED,                 8'd255, 7'd127, 5'd31}, 1'b0, '0},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd64,  5'd16}, 1'b0, '0},
    '{'{tmcw_pkg::OP_WRITE_CURSOR, 8'd128, 7'd0,   5'd0},  1'b0, '0},
    '{'{tmcw_pkg::OP_WRITE_AT,     tmcw_pkg::NEWLINE_CODE, 7'd80, 5'd24}, 1'b0, '0},
    '{'{tmcw_pkg::OP_READ_CELL,    8'd0,   7'd80,  5'd26}, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = '0;
  logic [7:0]  in_character = '0;
  logic [6:0]  in_column = '0;
  logic [4:0]  in_line = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [10:0] out_cursor_cell;
  logic [7:0]  out_read_character;
  logic [7:0]  out_read_attribute;
  logic        out_scrolled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  int     error_count = 0;
  longint cycle_count = 0;

  // Results that the console owes, oldest first.
  console_result_t owed_results [$];

  // The predictor's own copy of the console: cells hold the attribute in the
  // high byte and the character in the low byte.
  logic [15:0] shadow_cells [CELL_COUNT];
  int unsigned shadow_cursor;
  logic [7:0]  shadow_attribute;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_mode_character_writer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_op              (in_op),
    .in_character       (in_character),
    .in_column          (in_column),
    .in_line            (in_line),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_cursor_cell    (out_cursor_cell),
    .out_read_character (out_read_character),
    .out_read_attribute (out_read_attribute),
    .out_scrolled       (out_scrolled),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  // Column and row beyond the screen are pinned to the last column and row.
  function automatic int unsigned cell_index(logic [6:0] column, logic [4:0] line);
    int unsigned c;
    int unsigned r;
    c = (32'(column) >= COLS) ? COLS - 1 : 32'(column);
    r = (32'(line) >= ROWS) ? ROWS - 1 : 32'(line);
    return r * COLS + c;
  endfunction

  // Applies one item to the shadow console and returns the result it must produce.
  function automatic console_result_t console_step(console_item_t item);
    console_result_t res;
    int unsigned pos;
    int unsigned i;
    res = '0;
    case (item.op)
      tmcw_pkg::OP_WRITE_CURSOR, tmcw_pkg::OP_WRITE_AT: begin
        pos = (item.op == tmcw_pkg::OP_WRITE_AT) ? cell_index(item.column, item.line)
                                                 : shadow_cursor;
        if (pos >= CELL_COUNT) pos = CELL_COUNT - 1;
        // A newline stores nothing; the cursor lands on the next row's first cell.
        if (item.character == tmcw_pkg::NEWLINE_CODE) begin
          pos = (pos / COLS) * COLS + COLS - 1;
        end else begin
          shadow_cells[pos] = {shadow_attribute, item.character};
        end
        shadow_cursor = pos + 1;
        // Past the last cell: every row moves up, the last row becomes spaces
        // with its old attributes, and the cursor goes back one row.
        if (shadow_cursor >= CELL_COUNT) begin
          for (i = 0; i < CELL_COUNT - COLS; i++) shadow_cells[i] = shadow_cells[i + COLS];
          for (i = CELL_COUNT - COLS; i < CELL_COUNT; i++) begin
            shadow_cells[i] = {shadow_cells[i][15:8], tmcw_pkg::SPACE_CODE};
          end
          shadow_cursor = shadow_cursor - COLS;
          res.scrolled = 1'b1;
        end
      end
      tmcw_pkg::OP_READ_CELL: begin
        pos = cell_index(item.column, item.line);
        res.read_character = shadow_cells[pos][7:0];
        res.read_attribute = shadow_cells[pos][15:8];
      end
      default: begin
      end
    endcase
    res.cursor_cell = shadow_cursor[10:0];
    return res;
  endfunction

  // Presents one item after a random hold-off and waits until it is taken. The
  // valid stays high on return so that a following item can go out back to back.
  task automatic send_item(input console_item_t item, input logic has_result,
                           input console_result_t hand_result);
    console_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= item.op;
    in_character <= item.character;
    in_column    <= item.column;
    in_line      <= item.line;
    do @(posedge clk); while (!in_ready);
    // The predictor runs on every item so its state stays in step, even when
    // the table supplies the result.
    predicted = console_step(item);
    owed_results.push_back(has_result ? hand_result : predicted);
  endtask

  // Holds the input back until every owed result has come out.
  task automatic drain_results();
    if (owed_results.size() != 0) begin
      in_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clk);
    end
  endtask

  // The attribute is only changed with the console idle, so every item in
  // flight has already been written with the old value.
  task automatic write_attribute(input logic [7:0] value);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_attribute = value;
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
      error_count++;
    end
  endtask

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every result taken is compared field by field with the oldest one owed.
  always @(posedge clk) begin : check_results
    console_result_t owed;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got cursor_cell %0d", $time,
                 out_cursor_cell);
        error_count++;
      end else begin
        owed = owed_results.pop_front();
        compare_field("cursor_cell", 32'(owed.cursor_cell), 32'(out_cursor_cell));
        compare_field("read_character", 32'(owed.read_character),
                      32'(out_read_character));
        compare_field("read_attribute", 32'(owed.read_attribute),
                      32'(out_read_attribute));
        compare_field("scrolled", 32'(owed.scrolled), 32'(out_scrolled));
      end
    end
  end

  // Guards against a hang anywhere in the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    console_item_t item;
    logic [7:0]    attribute;
    int            phase;
    int            n;
    foreach (shadow_cells[i]) shadow_cells[i] = '0;
    shadow_cursor    = 0;
    shadow_attribute = tmcw_pkg::ATTR_RESET;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, back to back with no stalls.
    foreach (DIRECTED_ROWS[i]) begin
      send_item(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].has_result, DIRECTED_ROWS[i].result);
    end

    // Random part. The idling pattern cycles through four modes twice, and each
    // phase runs with its own attribute, the two extremes and the reset value among them.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      case (phase)
        0: attribute = 8'h00;
        1: attribute = 8'hFF;
        4: attribute = tmcw_pkg::ATTR_RESET;
        default: attribute = 8'($urandom_range(255));
      endcase
      write_attribute(attribute);

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Now and then the sender waits for the console to empty completely.
        if ($urandom_range(199) == 0) drain_results();
        // Mostly writes and reads. Columns and rows are mostly on screen, with
        // some beyond it to exercise saturation; a few newlines push the cursor
        // along quickly so that scrolls come up regularly.
        case ($urandom_range(19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: item.op = tmcw_pkg::OP_WRITE_CURSOR;
          9, 10, 11, 12, 13:         item.op = tmcw_pkg::OP_WRITE_AT;
          14, 15, 16, 17, 18:        item.op = tmcw_pkg::OP_READ_CELL;
          default:                   item.op = OP_UNUSED;
        endcase
        item.character = ($urandom_range(11) == 0) ? tmcw_pkg::NEWLINE_CODE
                                                   : 8'($urandom_range(255));
        item.column    = ($urandom_range(9) == 0) ? 7'($urandom_range(127, COLS))
                                                  : 7'($urandom_range(COLS - 1));
        item.line      = ($urandom_range(9) == 0) ? 5'($urandom_range(31, ROWS))
                                                  : 5'($urandom_range(ROWS - 1));
        send_item(item, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
src/tmcw_pkg.sv
src/tmcw_front.sv
src/tmcw_queue.sv
src/tmcw_back.sv
src/text_mode_character_writer.sv
test/testbench.sv
